// ===== design/qrs_pkg.sv =====
// ============================================================================
// qrs_pkg
// Types, widths and codes shared by the quadratic root solver modules.
// ============================================================================
package qrs_pkg;

  // Coefficient width (signed fixed point, 8 fraction bits)
  localparam int COEF_W = 16;
  // Discriminant and square root widths
  localparam int D_W    = 64;
  localparam int SQ_W   = 32;
  localparam int SQ_STEPS = 2;
  localparam int SQ_STG   = SQ_W / SQ_STEPS;
  // Root output width (Q16.16)
  localparam int ROOT_W = 32;
  // -b * 2^8 as a signed value
  localparam int NB_W   = COEF_W + 9;
  // Numerator -b*2^8 +/- sqrt, signed
  localparam int NUM_W  = ((NB_W > SQ_W + 1) ? NB_W : SQ_W + 1) + 1;
  // Dividend magnitude |num| * 2^7, rounded up to whole divider stages
  localparam int QRAW   = ((COEF_W + 8 > SQ_W) ? COEF_W + 8 : SQ_W) + 8;
  localparam int DIV_STEPS = 2;
  localparam int QUO_W  = ((QRAW + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
  localparam int DIV_STG = QUO_W / DIV_STEPS;

  // Root count codes
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
  } qrs_in_t;

  typedef struct packed {
    logic [1:0]               root_count;
    logic signed [ROOT_W-1:0] plus_root;
    logic signed [ROOT_W-1:0] minus_root;
    logic                     degenerate;
  } qrs_out_t;

endpackage

// ===== design/qrs_div.sv =====
// ============================================================================
// qrs_div
// Pipelined unsigned restoring divider, DIV_STEPS quotient bits per stage.
// ============================================================================
module qrs_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [qrs_pkg::QUO_W-1:0]  in_num,
  input  logic [qrs_pkg::COEF_W-1:0] in_den,
  output logic                       out_valid,
  output logic [qrs_pkg::QUO_W-1:0]  out_quo
);
  import qrs_pkg::*;

  // per-stage registers
  logic              valid_r [DIV_STG];
  logic [QUO_W-1:0]  num_r   [DIV_STG];
  logic [QUO_W-1:0]  quo_r   [DIV_STG];
  logic [COEF_W-1:0] rem_r   [DIV_STG];
  logic [COEF_W-1:0] den_r   [DIV_STG];

  for (genvar s = 0; s < DIV_STG; s++) begin : g_stg
    logic              v_in;
    logic [QUO_W-1:0]  num_in, num_v, quo_in, quo_v;
    logic [COEF_W-1:0] rem_in, rem_v, den_in;
    logic [COEF_W:0]   trial;

    if (s == 0) begin : g_first
      assign v_in   = in_valid;
      assign num_in = in_num;
      assign quo_in = '0;
      assign rem_in = '0;
      assign den_in = in_den;
    end else begin : g_next
      assign v_in   = valid_r[s-1];
      assign num_in = num_r[s-1];
      assign quo_in = quo_r[s-1];
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
    end

    // restoring steps: shift in one dividend bit, subtract when it fits
    always_comb begin
      num_v = num_in;
      quo_v = quo_in;
      rem_v = rem_in;
      trial = '0;
      for (int k = 0; k < DIV_STEPS; k++) begin
        trial = {rem_v, num_v[QUO_W-1]};
        num_v = {num_v[QUO_W-2:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          trial = trial - {1'b0, den_in};
          quo_v = {quo_v[QUO_W-2:0], 1'b1};
        end else begin
          quo_v = {quo_v[QUO_W-2:0], 1'b0};
        end
        rem_v = trial[COEF_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else begin
        valid_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      num_r[s] <= num_v;
      quo_r[s] <= quo_v;
      rem_r[s] <= rem_v;
      den_r[s] <= den_in;
    end
  end

  assign out_valid = valid_r[DIV_STG-1];
  assign out_quo   = quo_r[DIV_STG-1];

endmodule

// ===== design/quadratic_root_solver.sv =====
// ============================================================================
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c from signed Q8.8 coefficients, Q16.16 roots.
// ============================================================================
//
//  channel  | ports                    | handshake
//  ---------+--------------------------+--------------------------------------
//  input    | start, busy, in_data     | transaction when start && !busy
//  result   | out_valid, out_data      | one-cycle strobe, no backpressure
//
// One transaction can enter every cycle; busy is always low.
// Result path: input, product and discriminant registers, the 16-stage square
// root, the numerator register, the 20-stage dividers and the output register.
// Reset (synchronous, active low) clears all stage valid bits; data is not reset.
// The receiver cannot stall, so the pipeline never holds.
module quadratic_root_solver (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  qrs_pkg::qrs_in_t  in_data,
  output logic              out_valid,
  output qrs_pkg::qrs_out_t out_data
);
  import qrs_pkg::*;

  localparam int LAT = 3 + SQ_STG + 1 + DIV_STG + 1;
  localparam logic [QUO_W-1:0] LIM_POS = QUO_W'(64'h7FFF_FFFF);
  localparam logic [QUO_W-1:0] LIM_NEG = QUO_W'(64'h8000_0000);

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [NB_W-1:0]   nb;
    logic [1:0]               cnt;
    logic                     deg;
  } side_t;

  typedef struct packed {
    logic       neg_p;
    logic       neg_m;
    logic [1:0] cnt;
    logic       deg;
  } tag_t;

  assign busy = 1'b0;

  // Input register
  logic    in_valid_r;
  qrs_in_t in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_data;
  end

  // Products b*b and a*c
  logic                       mul_valid_r;
  logic signed [2*COEF_W-1:0] bb_r, ac_r;
  logic signed [COEF_W-1:0]   mul_a_r, mul_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else begin
      mul_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    bb_r    <= in_r.coef_b * in_r.coef_b;
    ac_r    <= in_r.coef_a * in_r.coef_c;
    mul_a_r <= in_r.coef_a;
    mul_b_r <= in_r.coef_b;
  end

  // Discriminant, root count and square root operand
  logic [D_W-1:0]    dsc_nxt, dsc_x_nxt;
  logic [D_W-1:0]    bb_ext, ac_ext;
  logic [COEF_W:0]   b_neg;
  side_t             dsc_side_nxt;
  logic              dsc_valid_r;
  logic [D_W-1:0]    dsc_x_r;
  side_t             dsc_side_r;

  always_comb begin
    bb_ext  = {{(D_W-2*COEF_W){bb_r[2*COEF_W-1]}}, bb_r};
    ac_ext  = {{(D_W-2*COEF_W){ac_r[2*COEF_W-1]}}, ac_r};
    dsc_nxt = bb_ext - {ac_ext[D_W-3:0], 2'b00};
    if (dsc_nxt[D_W-1:D_W-16] == '0) begin
      dsc_x_nxt = {dsc_nxt[D_W-17:0], 16'h0000};
    end else begin
      dsc_x_nxt = {1'b0, {(D_W-1){1'b1}}};
    end
    b_neg = -{mul_b_r[COEF_W-1], mul_b_r};
    dsc_side_nxt.a   = mul_a_r;
    dsc_side_nxt.nb  = {b_neg, 8'h00};
    dsc_side_nxt.deg = (mul_a_r == '0);
    priority if (dsc_side_nxt.deg || dsc_nxt[D_W-1]) begin
      dsc_side_nxt.cnt = CNT_NONE;
    end else if (dsc_nxt == '0) begin
      dsc_side_nxt.cnt = CNT_ONE;
    end else begin
      dsc_side_nxt.cnt = CNT_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dsc_valid_r <= 1'b0;
    end else begin
      dsc_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    dsc_x_r    <= dsc_x_nxt;
    dsc_side_r <= dsc_side_nxt;
  end

  // Square root pipeline, SQ_STEPS root bits per stage
  logic            sq_valid_r [SQ_STG];
  logic [D_W-1:0]  sq_x_r     [SQ_STG];
  logic [SQ_W+1:0] sq_rem_r   [SQ_STG];
  logic [SQ_W-1:0] sq_root_r  [SQ_STG];
  side_t           sq_side_r  [SQ_STG];

  for (genvar s = 0; s < SQ_STG; s++) begin : g_sq
    logic            v_in;
    logic [D_W-1:0]  x_in, x_v;
    logic [SQ_W+1:0] rem_in, rem_v;
    logic [SQ_W-1:0] root_in, root_v;
    logic [SQ_W+3:0] acc, trial;
    side_t           side_in;

    if (s == 0) begin : g_first
      assign v_in    = dsc_valid_r;
      assign x_in    = dsc_x_r;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = dsc_side_r;
    end else begin : g_next
      assign v_in    = sq_valid_r[s-1];
      assign x_in    = sq_x_r[s-1];
      assign rem_in  = sq_rem_r[s-1];
      assign root_in = sq_root_r[s-1];
      assign side_in = sq_side_r[s-1];
    end

    // digit-by-digit root: bring down two bits, try (root << 2) | 1
    always_comb begin
      x_v    = x_in;
      rem_v  = rem_in;
      root_v = root_in;
      acc    = '0;
      trial  = '0;
      for (int k = 0; k < SQ_STEPS; k++) begin
        acc   = {rem_v, x_v[D_W-1 -: 2]};
        trial = {2'b00, root_v, 2'b01};
        x_v   = {x_v[D_W-3:0], 2'b00};
        if (acc >= trial) begin
          acc    = acc - trial;
          root_v = {root_v[SQ_W-2:0], 1'b1};
        end else begin
          root_v = {root_v[SQ_W-2:0], 1'b0};
        end
        rem_v = acc[SQ_W+1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_valid_r[s] <= 1'b0;
      end else begin
        sq_valid_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      sq_x_r[s]    <= x_v;
      sq_rem_r[s]  <= rem_v;
      sq_root_r[s] <= root_v;
      sq_side_r[s] <= side_in;
    end
  end

  // Numerators -b*2^8 +/- sqrt, as magnitude * 2^7 and sign
  side_t                  sq_last;
  logic signed [NUM_W-1:0] num_p, num_m, nb_ext, s_ext;
  logic [NUM_W-1:0]        mag_p, mag_m;
  logic                    nm_valid_r;
  logic [QUO_W-1:0]        np_mag_r, nm_mag_r;
  logic [COEF_W-1:0]       den_r;
  tag_t                    nm_tag_r;

  always_comb begin
    sq_last = sq_side_r[SQ_STG-1];
    nb_ext  = {{(NUM_W-NB_W){sq_last.nb[NB_W-1]}}, sq_last.nb};
    s_ext   = {{(NUM_W-SQ_W){1'b0}}, sq_root_r[SQ_STG-1]};
    num_p   = nb_ext + s_ext;
    num_m   = nb_ext - s_ext;
    mag_p   = num_p[NUM_W-1] ? -num_p : num_p;
    mag_m   = num_m[NUM_W-1] ? -num_m : num_m;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_valid_r <= 1'b0;
    end else begin
      nm_valid_r <= sq_valid_r[SQ_STG-1];
    end
  end

  always_ff @(posedge clk) begin
    np_mag_r       <= QUO_W'({mag_p, 7'b000_0000});
    nm_mag_r       <= QUO_W'({mag_m, 7'b000_0000});
    den_r          <= sq_last.a[COEF_W-1] ? -sq_last.a : sq_last.a;
    nm_tag_r.neg_p <= num_p[NUM_W-1] ^ sq_last.a[COEF_W-1];
    nm_tag_r.neg_m <= num_m[NUM_W-1] ^ sq_last.a[COEF_W-1];
    nm_tag_r.cnt   <= sq_last.cnt;
    nm_tag_r.deg   <= sq_last.deg;
  end

  // Dividers for both roots
  logic             dp_valid, dm_valid;
  logic [QUO_W-1:0] quo_p, quo_m;

  qrs_div u_div_plus (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (nm_valid_r),
    .in_num    (np_mag_r),
    .in_den    (den_r),
    .out_valid (dp_valid),
    .out_quo   (quo_p)
  );

  qrs_div u_div_minus (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (nm_valid_r),
    .in_num    (nm_mag_r),
    .in_den    (den_r),
    .out_valid (dm_valid),
    .out_quo   (quo_m)
  );

  // Sign and count info alongside the dividers
  tag_t tag_r [DIV_STG];

  always_ff @(posedge clk) begin
    tag_r[0] <= nm_tag_r;
    for (int i = 1; i < DIV_STG; i++) begin
      tag_r[i] <= tag_r[i-1];
    end
  end

  // Saturate a signed quotient to 32 bits
  function automatic logic [ROOT_W-1:0] sat_root(logic [QUO_W-1:0] q, logic neg);
    logic [ROOT_W-1:0] r;
    if (neg) begin
      r = (q > LIM_NEG) ? LIM_NEG[ROOT_W-1:0] : -q[ROOT_W-1:0];
    end else begin
      r = (q > LIM_POS) ? LIM_POS[ROOT_W-1:0] : q[ROOT_W-1:0];
    end
    return r;
  endfunction

  // Output register
  tag_t     tag_last;
  qrs_out_t out_nxt;
  logic     out_valid_r;
  qrs_out_t out_data_r;

  always_comb begin
    tag_last           = tag_r[DIV_STG-1];
    out_nxt.root_count = tag_last.cnt;
    out_nxt.degenerate = tag_last.deg;
    out_nxt.plus_root  = '0;
    out_nxt.minus_root = '0;
    if (tag_last.cnt != CNT_NONE) begin
      out_nxt.plus_root = sat_root(quo_p, tag_last.neg_p);
    end
    if (tag_last.cnt == CNT_TWO) begin
      out_nxt.minus_root = sat_root(quo_m, tag_last.neg_m);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dp_valid && dm_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // every accepted transaction yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after accepted transaction");

  // degenerate results carry no roots
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.degenerate) |->
      (out_data.root_count == CNT_NONE && out_data.plus_root == '0 &&
       out_data.minus_root == '0))
    else $error("degenerate result with roots");

  // minus root only present for two distinct roots
  a_minus: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.root_count != CNT_TWO) |-> (out_data.minus_root == '0))
    else $error("minus root set without two roots");

  // both dividers stay in lockstep
  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    dp_valid == dm_valid)
    else $error("divider pipelines out of step");
`endif

endmodule

// ===== tb/sv/quadratic_root_solver_test.sv =====
// ============================================================================
// quadratic_root_solver_test
// Self-checking bench: directed coefficient table, then random sets, roots
// predicted in Q16.16 and compared field by field in arrival order.
// ============================================================================
module quadratic_root_solver_test;
  timeunit 1ns;
  timeprecision 1ps;
  import qrs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int RAND_PER_PHASE = 317;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  qrs_in_t  in_data = '0;
  logic     out_valid;
  qrs_out_t out_data;

  bit       failed = 1'b0;
  int       idle_pct = 0;
  int       quiet_cycles = 0;
  qrs_out_t root_queue[$];

  quadratic_root_solver dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Bitwise integer square root, rounded down
  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r, bt;
    r  = 0;
    bt = 64'h4000_0000_0000_0000;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  // num has 16 fraction bits; quotient num/(2a) in Q16.16, clamped to 32 bits
  function automatic logic signed [ROOT_W-1:0] root_q16(input longint num, input longint a);
    longint q;
    q = (num * 128) / a;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[ROOT_W-1:0];
  endfunction

  function automatic qrs_out_t solve_roots(input qrs_in_t t);
    qrs_out_t r;
    longint a, b, c, disc, nb;
    longint unsigned s;
    a = t.coef_a;
    b = t.coef_b;
    c = t.coef_c;
    r = '0;
    if (a == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    disc = b * b - 4 * a * c;
    nb   = -b * 256;
    if (disc == 0) begin
      r.root_count = CNT_ONE;
      r.plus_root  = root_q16(nb, a);
    end else if (disc > 0) begin
      s = int_sqrt(longint'(disc) << 16);
      r.root_count = CNT_TWO;
      r.plus_root  = root_q16(nb + longint'(s), a);
      r.minus_root = root_q16(nb - longint'(s), a);
    end
    return r;
  endfunction

  // Transaction monitor: predict on accept, check each strobe
  always @(posedge clk) begin
    qrs_out_t want;
    if (rst_n) begin
      if (start && !busy) root_queue.push_back(solve_roots(in_data));
      if (out_valid) begin
        if (root_queue.size() == 0) begin
          $display("%0t unexpected result: actual %p", $time, out_data);
          failed = 1'b1;
        end else begin
          want = root_queue.pop_front();
          if (out_data.root_count !== want.root_count) begin
            $display("%0t root_count exp %0d act %0d", $time, want.root_count,
                     out_data.root_count);
            failed = 1'b1;
          end
          if (out_data.plus_root !== want.plus_root) begin
            $display("%0t plus_root exp %0d act %0d", $time, want.plus_root,
                     out_data.plus_root);
            failed = 1'b1;
          end
          if (out_data.minus_root !== want.minus_root) begin
            $display("%0t minus_root exp %0d act %0d", $time, want.minus_root,
                     out_data.minus_root);
            failed = 1'b1;
          end
          if (out_data.degenerate !== want.degenerate) begin
            $display("%0t degenerate exp %0b act %0b", $time, want.degenerate,
                     out_data.degenerate);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid)) quiet_cycles <= 0;
    else if (rst_n) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[quadratic_root_solver] ERROR");
      $finish;
    end
  end

  // Drive one transaction from a falling edge, then idle cycle by cycle
  task automatic send_coefs(input qrs_in_t t);
    start   <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  function automatic logic signed [COEF_W-1:0] rand_coef();
    case ($urandom_range(5))
      0:       return COEF_W'(32'sh7fff - int'($urandom_range(2)));
      1:       return COEF_W'(-32'sh8000 + int'($urandom_range(2)));
      2:       return COEF_W'(int'($urandom_range(1023)) - 512);
      3:       return '0;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic qrs_in_t rand_coefs();
    qrs_in_t t;
    int ka, kt;
    if ($urandom_range(9) < 2) begin
      // double root: b = -2*a*t, c = a*t*t
      ka = int'($urandom_range(60)) - 30;
      if (ka == 0) ka = 1;
      kt = int'($urandom_range(40)) - 20;
      t.coef_a = COEF_W'(ka);
      t.coef_b = COEF_W'(-2 * ka * kt);
      t.coef_c = COEF_W'(ka * kt * kt);
    end else begin
      t.coef_a = rand_coef();
      t.coef_b = rand_coef();
      t.coef_c = rand_coef();
    end
    return t;
  endfunction

  typedef struct {
    qrs_in_t  coefs;
    bit       typed;
    qrs_out_t result;
  } stim_row_t;

  stim_row_t stim_table[] = '{
    // a zero: degenerate
    '{'{16'sd0, 16'sd256, 16'sd256}, 1'b1, '{CNT_NONE, 32'sd0, 32'sd0, 1'b1}},
    '{'{16'sd0, -16'sh8000, 16'sh7fff}, 1'b1, '{CNT_NONE, 32'sd0, 32'sd0, 1'b1}},
    // negative discriminant
    '{'{16'sd256, 16'sd0, 16'sd256}, 1'b1, '{CNT_NONE, 32'sd0, 32'sd0, 1'b0}},
    '{'{16'sh7fff, 16'sd0, 16'sh7fff}, 1'b1, '{CNT_NONE, 32'sd0, 32'sd0, 1'b0}},
    // double root at x = 1.0
    '{'{16'sd256, -16'sd512, 16'sd256}, 1'b1, '{CNT_ONE, 32'sd65536, 32'sd0, 1'b0}},
    // two roots, saturation, extremes; one row with a double root, two with none
    '{'{16'sd256, 16'sd0, -16'sd256}, 1'b0, '0},
    '{'{16'sd1, 16'sh7fff, 16'sd0}, 1'b0, '0},
    '{'{16'sd1, -16'sh8000, 16'sd0}, 1'b0, '0},
    '{'{-16'sd1, 16'sh7fff, 16'sh7fff}, 1'b0, '0},
    '{'{-16'sh8000, -16'sh8000, 16'sh7fff}, 1'b0, '0},
    '{'{16'sh7fff, 16'sh7fff, -16'sh8000}, 1'b0, '0},
    '{'{-16'sh8000, 16'sh7fff, -16'sh8000}, 1'b0, '0},
    '{'{16'sh7fff, -16'sh8000, -16'sh8000}, 1'b0, '0},
    '{'{-16'sd256, 16'sd256, 16'sd512}, 1'b0, '0},
    '{'{-16'sd1, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'shffff, 16'shffff, 16'shffff}, 1'b0, '0}
  };

  initial begin
    qrs_in_t t;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table: typed rows must agree with the predictor
    foreach (stim_table[i]) begin
      if (stim_table[i].typed && solve_roots(stim_table[i].coefs) !== stim_table[i].result) begin
        $display("%0t table row %0d exp %p act %p", $time, i, stim_table[i].result,
                 solve_roots(stim_table[i].coefs));
        failed = 1'b1;
      end
      send_coefs(stim_table[i].coefs);
    end

    // Random phases: idle 30%, then 48%, then none
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 30 : (ph == 1) ? 48 : 0;
      repeat (RAND_PER_PHASE) begin
        t = rand_coefs();
        send_coefs(t);
      end
    end
    start <= 1'b0;

    while (root_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("[quadratic_root_solver] OK");
    end else begin
      $display("[quadratic_root_solver] ERROR");
    end
    $finish;
  end

endmodule

// ===== quadratic_root_solver.f =====
design/qrs_pkg.sv
design/qrs_div.sv
design/quadratic_root_solver.sv
tb/sv/quadratic_root_solver_test.sv
